@@ hw/rtl/paper_map_color_grade_unit_macros.svh @@
// Assertion macros for the paper map color grade unit.
// No dependencies; assumes clk_i and rst_ni exist in the including module.
`ifndef PAPER_MAP_COLOR_GRADE_UNIT_MACROS_SVH
`define PAPER_MAP_COLOR_GRADE_UNIT_MACROS_SVH

// Combinational implication, checked on every rising clock edge out of reset.
`define PMCG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PMCG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/pmcg_pkg.sv @@
// Package for the paper map color grade unit: widths, coefficients, register indexes
// and the fixed-point product/round helpers. No dependencies.
package pmcg_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned GAIN_W    = 17;
  localparam int unsigned LUMA_W    = 24;
  // channel value: byte with 16 fraction bits, signed, with headroom
  localparam int unsigned VAL_W     = 26;
  localparam int unsigned PROD_W    = 44;
  localparam int unsigned NLANE     = 3;
  localparam int unsigned NSTG      = 6;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DESAT      = 2'd0,
    REG_CONTRAST   = 2'd1,
    REG_TINT_BLEND = 2'd2
  } pmcg_reg_e;

  localparam logic [COEF_W-1:0] DESAT_RST      = 16'd32768;
  localparam logic [COEF_W-1:0] CONTRAST_RST   = 16'd56361;
  localparam logic [COEF_W-1:0] TINT_BLEND_RST = 16'd7864;

  // Rec.601 weights, sum to 1.0
  localparam logic [COEF_W-1:0] LUMA_COEF [NLANE] = '{16'd19595, 16'd38470, 16'd7471};
  // paper tint in value scale (255 * Q0.16 code)
  localparam logic signed [VAL_W-1:0] TINT_VAL [NLANE] =
    '{26'sd15040410, 26'sd14037750, 26'sd11363820};
  // per-channel gains, Q1.16
  localparam logic [GAIN_W-1:0] GAIN_COEF [NLANE] = '{17'd68813, 17'd65536, 17'd57672};

  localparam logic signed [VAL_W-1:0]  VAL_ONE  = 26'sd16711680;
  localparam logic signed [VAL_W-1:0]  VAL_HALF = 26'sd8355840;
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(32768);

  // value times unsigned coefficient (Q0.16 or Q1.16), full precision
  function automatic logic signed [PROD_W-1:0] mul_q(input logic signed [VAL_W-1:0] v,
                                                     input logic [GAIN_W-1:0] c);
    logic signed [GAIN_W:0] cs;
    cs = $signed({1'b0, c});
    return v * cs;
  endfunction

  // drop 16 fraction bits, rounding half up (floor of p + 0.5)
  function automatic logic signed [VAL_W-1:0] rnd_q(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + RND_HALF;
    return VAL_W'(t >>> 16);
  endfunction

endpackage

@@ hw/rtl/paper_map_color_grade_unit.sv @@
// Paper map color grade unit: aged-paper look on RGBA8 pixels.
// Uses pmcg_pkg and paper_map_color_grade_unit_macros.svh.
//
// Channels: the pixel input (in_valid_i / in_stall_o with red, green, blue,
// alpha bytes) and the graded output (out_valid_o / out_stall_i). A beat moves
// when valid is high and stall is low at a rising edge. Three 16-bit Q0.16
// registers (desaturate, contrast, tint blend) are written over the cfg channel
// (cfg_valid_i / cfg_ready_o, index and data); cfg_ready_o is always high and
// an index past the register list is ignored. Write them only while idle.
//
// Throughput is one pixel per clock while the receiver does not stall. Six
// register stages: luma, then desaturate, contrast, tint blend and gain with
// one multiply per lane each, then clamp and round into the output register.
// A stall from the receiver holds the output register; stages behind it keep
// filling bubbles, and in_stall_o rises only once every stage holds a pixel.
// Reset empties the pipeline and loads the register defaults
// (0.50, 0.86, 0.12); no clearing pass is needed.
module paper_map_color_grade_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pmcg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pmcg_pkg::COEF_W-1:0]      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [pmcg_pkg::BYTE_W-1:0]      red_in_i,
  input  logic [pmcg_pkg::BYTE_W-1:0]      green_in_i,
  input  logic [pmcg_pkg::BYTE_W-1:0]      blue_in_i,
  input  logic [pmcg_pkg::BYTE_W-1:0]      alpha_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [pmcg_pkg::BYTE_W-1:0]      red_out_o,
  output logic [pmcg_pkg::BYTE_W-1:0]      green_out_o,
  output logic [pmcg_pkg::BYTE_W-1:0]      blue_out_o,
  output logic [pmcg_pkg::BYTE_W-1:0]      alpha_out_o
);
  import pmcg_pkg::*;

  `include "paper_map_color_grade_unit_macros.svh"

  // configuration registers
  logic [COEF_W-1:0] desat_q, contrast_q, mix_q;

  // pipeline control
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] en;

  // stage payloads
  logic [BYTE_W-1:0]              alpha_q [NSTG];
  logic [BYTE_W-1:0]              byte_in [NLANE];
  logic [BYTE_W-1:0]              byte1_q [NLANE];
  logic [LUMA_W-1:0]              luma_d, luma1_q;
  logic [BYTE_W-1:0]              byte2_q [NLANE];
  logic signed [PROD_W-1:0]       p2_d [NLANE], p2_q [NLANE];
  logic signed [PROD_W-1:0]       p3_d [NLANE], p3_q [NLANE];
  logic signed [VAL_W-1:0]        v4_d [NLANE], v4_q [NLANE];
  logic signed [PROD_W-1:0]       p4_d [NLANE], p4_q [NLANE];
  logic signed [PROD_W-1:0]       p5_d [NLANE], p5_q [NLANE];
  logic [BYTE_W-1:0]              o6_d [NLANE], o6_q [NLANE];

  logic signed [VAL_W-1:0]        v_src [NLANE];
  logic signed [VAL_W-1:0]        v1    [NLANE];
  logic signed [VAL_W-1:0]        v3    [NLANE];
  logic signed [VAL_W-1:0]        v5    [NLANE];
  logic [LUMA_W-1:0]              vc    [NLANE];
  logic [LUMA_W:0]                vr    [NLANE];

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desat_q    <= DESAT_RST;
      contrast_q <= CONTRAST_RST;
      mix_q      <= TINT_BLEND_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_DESAT:      desat_q    <= cfg_data_i;
        REG_CONTRAST:   contrast_q <= cfg_data_i;
        REG_TINT_BLEND: mix_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  // a stage loads when it is empty or the stage after it loads
  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || !out_stall_i;
    for (int s = NSTG - 2; s >= 0; s--) begin
      en[s] = !vld_q[s] || en[s+1];
    end
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int s = 1; s < NSTG; s++) begin
        if (en[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  // alpha rides along the pipeline untouched
  always_ff @(posedge clk_i) begin
    if (en[0]) alpha_q[0] <= alpha_in_i;
    for (int s = 1; s < NSTG; s++) begin
      if (en[s]) alpha_q[s] <= alpha_q[s-1];
    end
  end

  // ---------------------------------------------------------------- datapath
  assign byte_in[0] = red_in_i;
  assign byte_in[1] = green_in_i;
  assign byte_in[2] = blue_in_i;

  always_comb begin
    luma_d = (LUMA_W'(red_in_i)   * LUMA_W'(LUMA_COEF[0]))
           + (LUMA_W'(green_in_i) * LUMA_W'(LUMA_COEF[1]))
           + (LUMA_W'(blue_in_i)  * LUMA_W'(LUMA_COEF[2]));
  end

  always_comb begin
    for (int c = 0; c < NLANE; c++) begin
      // stage 2: pull toward luma
      v_src[c] = $signed({2'b00, byte1_q[c], 16'h0000});
      p2_d[c]  = mul_q($signed({2'b00, luma1_q}) - v_src[c], GAIN_W'(desat_q));
      // stage 3: contrast about mid-grey
      v1[c]    = $signed({2'b00, byte2_q[c], 16'h0000}) + rnd_q(p2_q[c]);
      p3_d[c]  = mul_q(v1[c] - VAL_HALF, GAIN_W'(contrast_q));
      // stage 4: toward paper tint
      v4_d[c]  = rnd_q(p3_q[c]) + VAL_HALF;
      p4_d[c]  = mul_q(TINT_VAL[c] - v4_d[c], GAIN_W'(mix_q));
      // stage 5: channel gain
      v3[c]    = v4_q[c] + rnd_q(p4_q[c]);
      p5_d[c]  = mul_q(v3[c], GAIN_COEF[c]);
      // stage 6: clamp to [0,1], round half up to a byte
      v5[c]    = rnd_q(p5_q[c]);
      if (v5[c] < 0) begin
        vc[c] = '0;
      end else if (v5[c] > VAL_ONE) begin
        vc[c] = LUMA_W'(VAL_ONE);
      end else begin
        vc[c] = v5[c][LUMA_W-1:0];
      end
      vr[c]    = (LUMA_W+1)'(vc[c]) + (LUMA_W+1)'(32768);
      o6_d[c]  = vr[c][LUMA_W-1:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      luma1_q <= luma_d;
      byte1_q <= byte_in;
    end
    if (en[1]) begin
      byte2_q <= byte1_q;
      p2_q    <= p2_d;
    end
    if (en[2]) p3_q <= p3_d;
    if (en[3]) begin
      v4_q <= v4_d;
      p4_q <= p4_d;
    end
    if (en[4]) p5_q <= p5_d;
    if (en[5]) o6_q <= o6_d;
  end

  assign out_valid_o = vld_q[NSTG-1];
  assign red_out_o   = o6_q[0];
  assign green_out_o = o6_q[1];
  assign blue_out_o  = o6_q[2];
  assign alpha_out_o = alpha_q[NSTG-1];

  // ---------------------------------------------------------------- checks
  `PMCG_ASSERT_IMP(a_stall_needs_backpressure, in_stall_o, out_valid_o && out_stall_i,
                   "input stalled without output backpressure")
  `PMCG_ASSERT_IMP(a_full_and_stalled_blocks, (&vld_q) && out_stall_i, in_stall_o,
                   "full pipeline accepted a beat under stall")
  `PMCG_ASSERT_NXT(a_desat_write, cfg_valid_i && cfg_index_i == REG_DESAT,
                   desat_q == $past(cfg_data_i), "desaturate register write lost")
  `PMCG_ASSERT_NXT(a_hold_on_stall, out_valid_o && out_stall_i,
                   out_valid_o && $stable(o6_q[0]) && $stable(alpha_q[NSTG-1]),
                   "output register changed under stall")

endmodule

@@ tb/tb_paper_map_color_grade_unit.sv @@
// Self-checking testbench for paper_map_color_grade_unit: random RGBA pixels with
// bursty input, patterned output stalls and several register settings.
// Depends on pmcg_pkg and the unit's RTL; the expected pixels come from a local predictor.
`timescale 1ns / 1ps

module tb_paper_map_color_grade_unit;
  import pmcg_pkg::*;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 225;
  localparam int NUM_PHASES  = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  localparam rgba_t CORNER_PIXELS [9] = '{
    32'h00000000, 32'hFFFFFFFF, 32'hFF0000FF, 32'h00FF00FF, 32'h0000FFFF,
    32'h80808055, 32'hAAAAAAAA, 32'h55555555, 32'h01FE7F80
  };

  // Grades pixels with the current register copy and checks output beats in order.
  class grade_scoreboard;
    localparam longint FULL_SCALE = 64'sd16711680;
    localparam longint HALF_SCALE = 64'sd8355840;
    localparam longint LUMA_WT [3] = '{19595, 38470, 7471};
    localparam longint PAPER_TINT [3] = '{15040410, 14037750, 11363820};
    localparam longint LANE_GAIN [3] = '{68813, 65536, 57672};

    logic [15:0] desat;
    logic [15:0] contrast;
    logic [15:0] tint_blend;
    rgba_t       graded_q[$];
    int          errors;

    function new();
      desat      = DESAT_RST;
      contrast   = CONTRAST_RST;
      tint_blend = TINT_BLEND_RST;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
      case (idx)
        REG_DESAT:      desat = data;
        REG_CONTRAST:   contrast = data;
        REG_TINT_BLEND: tint_blend = data;
        default: ;
      endcase
    endfunction

    // floor((v * c + 2^15) / 2^16); all operands signed 64-bit
    function longint round_q16(longint v, longint c);
      return (v * c + 64'sd32768) >>> 16;
    endfunction

    function logic [7:0] grade_lane(int lane, longint chan, longint luma);
      longint v;
      v = chan <<< 16;
      v = v + round_q16(luma - v, desat);
      v = round_q16(v - HALF_SCALE, contrast) + HALF_SCALE;
      v = v + round_q16(PAPER_TINT[lane] - v, tint_blend);
      v = round_q16(v, LANE_GAIN[lane]);
      if (v < 0) v = 0;
      if (v > FULL_SCALE) v = FULL_SCALE;
      return 8'((v + 64'sd32768) >>> 16);
    endfunction

    function void note_pixel(rgba_t px);
      longint chan [3];
      longint luma;
      rgba_t  graded;
      chan[0] = longint'(px.red);
      chan[1] = longint'(px.green);
      chan[2] = longint'(px.blue);
      luma = 0;
      for (int i = 0; i < 3; i++) luma += chan[i] * LUMA_WT[i];
      graded.red   = grade_lane(0, chan[0], luma);
      graded.green = grade_lane(1, chan[1], luma);
      graded.blue  = grade_lane(2, chan[2], luma);
      graded.alpha = px.alpha;
      graded_q.push_back(graded);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(rgba_t got);
      rgba_t want;
      if (graded_q.size() == 0) begin
        $error("output beat with no pixel pending: %h", got);
        errors++;
        return;
      end
      want = graded_q.pop_front();
      check_field("red_out", want.red, got.red);
      check_field("green_out", want.green, got.green);
      check_field("blue_out", want.blue, got.blue);
      check_field("alpha_out", want.alpha, got.alpha);
    endfunction

    function int pending();
      return graded_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  rgba_t                pix_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  rgba_t                pix_out;

  grade_scoreboard sb;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int cycle_count = 0;

  paper_map_color_grade_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .red_in_i    (pix_in.red),
    .green_in_i  (pix_in.green),
    .blue_in_i   (pix_in.blue),
    .alpha_in_i  (pix_in.alpha),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .red_out_o   (pix_out.red),
    .green_out_o (pix_out.green),
    .blue_out_o  (pix_out.blue),
    .alpha_out_o (pix_out.alpha)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(pix_out);
  end

  // Output stall pattern: runs of random length, plus one long hold on request.
  initial begin : stall_pattern
    int run_left;
    bit hold_done;
    run_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        run_left = 0;
      end else if (run_left == 0) begin
        out_stall <= ($urandom_range(99, 0) < stall_pct);
        run_left = $urandom_range(6, 1);
      end else begin
        run_left--;
      end
    end
  end

  // Holds the beat until it is taken; leaves valid high for a following beat.
  task automatic offer_pixel(input rgba_t px);
    in_valid <= 1'b1;
    pix_in   <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel(px);
  endtask

  task automatic pause_input(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Only while the pipeline is empty. The spare index must leave all registers alone.
  task automatic apply_config(input logic [15:0] d, input logic [15:0] c, input logic [15:0] m);
    write_reg(REG_DESAT, d);
    write_reg(REG_CONTRAST, c);
    write_reg(REG_TINT_BLEND, m);
    write_reg(REG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(3, 0))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic rgba_t rand_pixel();
    rgba_t px;
    px = rgba_t'($urandom);
    // now and then pin color channels to the rails to reach the clamps
    if ($urandom_range(5, 0) == 0) begin
      for (int i = 1; i < 4; i++) begin
        case ($urandom_range(2, 0))
          0: px[8*i +: 8] = 8'h00;
          1: px[8*i +: 8] = 8'hFF;
          default: ;
        endcase
      end
    end
    return px;
  endfunction

  task automatic run_stream(input int count, input int max_gap);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(24, 1);
      if (burst > left) burst = left;
      repeat (burst) offer_pixel(rand_pixel());
      left -= burst;
      if (max_gap > 0) pause_input($urandom_range(max_gap, 0));
    end
  endtask

  initial begin : stimulus
    int pct_tbl [NUM_PHASES];
    int gap_tbl [NUM_PHASES];
    pct_tbl = '{0, 30, 50, 80, 20, 35, 60, 40};
    gap_tbl = '{0, 4, 0, 10, 2, 3, 8, 6};
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners under the reset settings
    foreach (CORNER_PIXELS[i]) offer_pixel(CORNER_PIXELS[i]);
    drain();
    // full desaturate and contrast, no paper: white red saturates through its gain
    apply_config(16'hFFFF, 16'hFFFF, 16'h0000);
    for (int i = 0; i < 5; i++) offer_pixel(CORNER_PIXELS[i]);
    drain();
    // everything collapses onto the paper tint
    apply_config(16'h0000, 16'h0000, 16'hFFFF);
    for (int i = 0; i < 5; i++) offer_pixel(CORNER_PIXELS[i]);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        4: apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        5: apply_config(16'h0000, 16'h0000, 16'h0000);
        7: apply_config(DESAT_RST, CONTRAST_RST, TINT_BLEND_RST);
        default: apply_config(pick_coef(), pick_coef(), pick_coef());
      endcase
      stall_pct = pct_tbl[ph];
      // long output hold while input keeps streaming: pipeline fills, input stalls
      if (ph == 2) hold_req = 1'b1;
      run_stream(PHASE_ITEMS, gap_tbl[ph]);
      drain();
    end

    stall_pct = 0;
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/pmcg_pkg.sv
hw/rtl/paper_map_color_grade_unit.sv
tb/tb_paper_map_color_grade_unit.sv
